@@ hdl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [6:0] PadChar   = 7'd61;  // '='
  localparam logic [6:0] UpperBase = 7'd65;  // 'A'
  localparam logic [6:0] LowerBase = 7'd97;  // 'a'
  localparam logic [6:0] DigitBase = 7'd48;  // '0'
  localparam logic [6:0] PlusChar  = 7'd43;  // '+'
  localparam logic [6:0] SlashChar = 7'd47;  // '/'

  // One complete or zero-filled 24-bit group, ready for the serializer.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  held;  // data bytes in the group, 1 to 3
    logic        last;  // group closes the stream
  } b64e_group_t;

  // Map a 6-bit value onto the standard alphabet.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = UpperBase + w;
    end else if (v < 6'd52) begin
      c = LowerBase + w - 7'd26;
    end else if (v < 6'd62) begin
      c = DigitBase + w - 7'd52;
    end else if (v == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Collects input bytes into 24-bit groups and hands each closed group on.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          data_byte_i,
  input  wire                 end_of_data_i,
  output logic                grp_valid_o,
  input  wire                 grp_ready_i,
  output b64e_pkg::b64e_group_t grp_o
);
  import b64e_pkg::*;

  logic [15:0] pend_q, pend_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pos;
  logic        closes;
  logic        accept;

  // A position of three never arises; treat it as the start of a group.
  assign pos    = (pos_q == 2'd3) ? 2'd0 : pos_q;
  assign closes = end_of_data_i || (pos == 2'd2);

  assign in_ready_o  = grp_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign grp_valid_o = in_valid_i && closes;

  always_comb begin
    case (pos)
      2'd1:    grp_o.bits = {pend_q[7:0], data_byte_i, 8'd0};
      2'd2:    grp_o.bits = {pend_q, data_byte_i};
      default: grp_o.bits = {data_byte_i, 16'd0};
    endcase
    grp_o.held = pos + 2'd1;
    grp_o.last = end_of_data_i;
  end

  always_comb begin
    pend_d = pend_q;
    pos_d  = pos_q;
    if (accept) begin
      if (closes) begin
        pend_d = 16'd0;
        pos_d  = 2'd0;
      end else begin
        pend_d = {pend_q[7:0], data_byte_i};
        if (pos == 2'd0) begin
          pend_d = {8'd0, data_byte_i};
        end
        pos_d = pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 16'd0;
      pos_q  <= 2'd0;
    end else begin
      pend_q <= pend_d;
      pos_q  <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of closed groups between the byte collector and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wr_valid_i,
  output logic                  wr_ready_o,
  input  b64e_pkg::b64e_group_t wr_data_i,
  output logic                  rd_valid_o,
  input  wire                   rd_ready_i,
  output b64e_pkg::b64e_group_t rd_data_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  b64e_group_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Serializes each group into four characters, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   grp_valid_i,
  output logic                  grp_ready_o,
  input  b64e_pkg::b64e_group_t grp_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [6:0]            out_char_o,
  output logic                  group_end_o,
  output logic                  stream_end_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [6:0] char_q;
  logic       gend_q, send_q;
  logic       load;
  logic [5:0] sextet;
  logic       pad;
  logic [6:0] char_d;

  assign load        = grp_valid_i && (!valid_q || out_ready_i);
  assign grp_ready_o = load && (idx_q == 2'd3);

  always_comb begin
    case (idx_q)
      2'd0:    sextet = grp_i.bits[23:18];
      2'd1:    sextet = grp_i.bits[17:12];
      2'd2:    sextet = grp_i.bits[11:6];
      default: sextet = grp_i.bits[5:0];
    endcase
    pad    = ((idx_q == 2'd2) && (grp_i.held < 2'd2)) ||
             ((idx_q == 2'd3) && (grp_i.held < 2'd3));
    char_d = pad ? PadChar : sextet_char(sextet);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      gend_q <= (idx_q == 2'd3);
      send_q <= (idx_q == 2'd3) && grp_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        // drop the transaction once taken
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign out_char_o   = char_q;
  assign group_end_o  = gend_q;
  assign stream_end_o = send_q;

endmodule

`default_nettype wire

@@ hdl/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Standard base64 encoder over a byte stream with end-of-stream padding.
// ----------------------------------------------------------------------------
// Bytes enter on the input channel, one per transaction, the last of a stream
// marked by end_of_data_i. Every third byte, or the marked byte, closes a
// group that goes into a short queue; a serializer then sends four characters
// per group, one per cycle while the output is not stalled, with '=' padding
// for a short final group. group_end_o marks the fourth character and
// stream_end_o the final one. The input takes a byte every cycle while the
// queue has room; sustained rate is set by the serializer. A byte that closes
// a group is first written into the queue and only then loaded into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] data_byte_i,
  input  wire        end_of_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [6:0] out_char_o,
  output logic       group_end_o,
  output logic       stream_end_o
);
  import b64e_pkg::*;

  b64e_group_t wr_grp, rd_grp;
  logic        wr_valid, wr_ready;
  logic        rd_valid, rd_ready;

  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .end_of_data_i,
    .grp_valid_o (wr_valid),
    .grp_ready_i (wr_ready),
    .grp_o       (wr_grp)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_data_i  (wr_grp),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_data_o  (rd_grp)
  );

  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .grp_valid_i (rd_valid),
    .grp_ready_o (rd_ready),
    .grp_i       (rd_grp),
    .out_valid_o,
    .out_ready_i,
    .out_char_o,
    .group_end_o,
    .stream_end_o
  );

endmodule

`default_nettype wire
